// File: hdl/pbfdl_pkg.sv
`timescale 1ns / 1ps
// pbfdl_pkg: shared types, fixed-point constants and saturating helpers
// for the pbf density/lambda unit; no dependencies
package pbfdl_pkg;

  localparam int FracBits  = 16;
  localparam int HqShift   = 32 - FracBits;
  localparam int Q2fR      = (2 * FracBits >= 32) ? 2 * FracBits - 32 : 0;
  localparam int Q2fL      = (2 * FracBits < 32) ? 32 - 2 * FracBits : 0;
  localparam int SqrtShift = 64 - 2 * FracBits;
  localparam int QDepth    = 2;
  localparam int QPtrW     = (QDepth > 1) ? $clog2(QDepth) : 1;

  localparam logic [63:0] RMin  = 64'd429497;
  localparam logic [63:0] OneQ  = 64'h0000_0001_0000_0000;
  localparam logic [63:0] Ones  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [62:0] Max63 = 63'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [30:0] HReset     = 31'd1 << FracBits;
  localparam logic [62:0] Poly6Reset = 63'h0000_0001_0000_0000;
  localparam logic [62:0] SpikyReset = 63'h0000_0001_0000_0000;
  localparam logic [30:0] RestReset  = 31'd1 << FracBits;

  typedef enum logic [1:0] {
    REG_H     = 2'd0,
    REG_POLY6 = 2'd1,
    REG_SPIKY = 2'd2,
    REG_REST  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [30:0] h;
    logic [62:0] poly6;
    logic [62:0] spiky;
    logic [30:0] rest;
  } cfg_t;

  typedef struct packed {
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic             present;
    logic             last;
  } item_t;

  function automatic logic [63:0] add_u64(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? Ones : s[63:0];
  endfunction

  function automatic logic [63:0] add_s64(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    return s[63:0];
  endfunction

  function automatic logic [62:0] sat63(logic [63:0] v);
    return v[63] ? Max63 : v[62:0];
  endfunction

  function automatic logic [63:0] abs64(logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic [63:0] q2f(logic [63:0] v);
    if (2 * FracBits >= 32) return v >> Q2fR;
    if (v > (Ones >> Q2fL)) return Ones;
    return v << Q2fL;
  endfunction

endpackage

// File: hdl/pbfdl_front.sv
`timescale 1ns / 1ps
// pbfdl_front: accepts pair beats, forms per-axis distance sign/magnitude
// and holds them in a short queue; uses pbfdl_pkg
module pbfdl_front import pbfdl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] center_z_i,
  input  logic signed [31:0] neighbor_x_i,
  input  logic signed [31:0] neighbor_y_i,
  input  logic signed [31:0] neighbor_z_i,
  input  logic               neighbor_present_i,
  input  logic               last_neighbor_i,
  output logic               item_valid_o,
  input  logic               item_ready_i,
  output item_t              item_o
);

  item_t             q_mem [QDepth];
  logic [QPtrW-1:0]  wr_q, rd_q;
  logic [QPtrW:0]    cnt_q;
  item_t             new_item;
  logic [2:0][31:0]  cen, nbr;
  logic [32:0]       diff [3];
  logic [32:0]       absd [3];
  logic              push, pop;

  always_comb begin
    cen = {center_z_i, center_y_i, center_x_i};
    nbr = {neighbor_z_i, neighbor_y_i, neighbor_x_i};
    new_item.present = neighbor_present_i;
    new_item.last    = last_neighbor_i;
    for (int k = 0; k < 3; k++) begin
      diff[k] = {cen[k][31], cen[k]} - {nbr[k][31], nbr[k]};
      absd[k] = diff[k][32] ? (~diff[k] + 33'd1) : diff[k];
      new_item.neg[k] = diff[k][32];
      new_item.mag[k] = absd[k][31:0];
    end
  end

  assign in_ready_o   = (cnt_q < (QPtrW+1)'(QDepth));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = q_mem[rd_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + QPtrW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + QPtrW'(1);
      end
      if (push && !pop) cnt_q <= cnt_q + (QPtrW+1)'(1);
      else if (pop && !push) cnt_q <= cnt_q - (QPtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_q] <= new_item;
  end

endmodule

// File: hdl/pbfdl_mul.sv
`timescale 1ns / 1ps
// pbfdl_mul: saturating Q32.32 product over four 32x32 partial products,
// one per cycle; uses pbfdl_pkg
module pbfdl_mul import pbfdl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] res_o
);

  logic [63:0] a_q, b_q, prod_q, acc_q;
  logic [2:0]  cnt_q;
  logic        busy_q, done_q;
  logic [31:0] op_a, op_b;
  logic [63:0] prod_d;
  logic [1:0]  use_idx;

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    begin op_a = a_q[63:32]; op_b = b_q[63:32]; end
      2'd1:    begin op_a = a_q[31:0];  op_b = b_q[63:32]; end
      2'd2:    begin op_a = a_q[63:32]; op_b = b_q[31:0];  end
      default: begin op_a = a_q[31:0];  op_b = b_q[31:0];  end
    endcase
    prod_d  = {32'd0, op_a} * {32'd0, op_b};
    use_idx = cnt_q[1:0] - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 3'd4);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd4) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      if (cnt_q != 3'd4) prod_q <= prod_d;
      if (cnt_q != 3'd0) begin
        case (use_idx)
          2'd0:    acc_q <= (prod_q[63:32] != '0) ? Ones : {prod_q[31:0], 32'd0};
          2'd1:    acc_q <= add_u64(acc_q, prod_q);
          2'd2:    acc_q <= add_u64(acc_q, prod_q);
          default: acc_q <= add_u64(acc_q, {32'd0, prod_q[63:32]});
        endcase
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

// File: hdl/pbfdl_div.sv
`timescale 1ns / 1ps
// pbfdl_div: saturating Q32.32 quotient, restoring division one bit a cycle;
// uses pbfdl_pkg
module pbfdl_div import pbfdl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] d_i,
  output logic        done_o,
  output logic [63:0] res_o
);

  logic [63:0] rem_q, lo_q, quo_q, d_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [63:0] rem2;
  logic        ge;
  logic        early;

  always_comb begin
    rem2  = {rem_q[62:0], lo_q[63]};
    ge    = rem_q[63] || (rem2 >= d_q);
    early = (d_i == '0) || ({32'd0, a_i[63:32]} >= d_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= '0;
        busy_q <= !early;
        done_q <= early;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      d_q   <= d_i;
      rem_q <= {32'd0, a_i[63:32]};
      lo_q  <= {a_i[31:0], 32'd0};
      quo_q <= early ? Ones : '0;
    end else if (busy_q) begin
      rem_q <= ge ? rem2 - d_q : rem2;
      lo_q  <= {lo_q[62:0], 1'b0};
      quo_q <= {quo_q[62:0], ge};
    end
  end

  assign done_o = done_q;
  assign res_o  = quo_q;

endmodule

// File: hdl/pbfdl_sqrt.sv
`timescale 1ns / 1ps
// pbfdl_sqrt: integer square root of the squared distance taken to Q32.32,
// two radicand bits a cycle; uses pbfdl_pkg
module pbfdl_sqrt import pbfdl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] v_i,
  output logic        done_o,
  output logic [63:0] res_o
);

  logic [127:0] sh_q;
  logic [63:0]  rem_q, root_q;
  logic [5:0]   cnt_q;
  logic         busy_q, done_q;
  logic [63:0]  rem2, trial;

  always_comb begin
    rem2  = {rem_q[61:0], sh_q[127:126]};
    trial = {root_q[61:0], 2'b01};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q   <= {64'd0, v_i} << SqrtShift;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      sh_q <= {sh_q[125:0], 2'b00};
      if (rem2 >= trial) begin
        rem_q  <= rem2 - trial;
        root_q <= {root_q[62:0], 1'b1};
      end else begin
        rem_q  <= rem2;
        root_q <= {root_q[62:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = root_q;

endmodule

// File: hdl/pbfdl_back.sv
`timescale 1ns / 1ps
// pbfdl_back: sequencer that runs kernel, gradient and lambda math on the
// shared multiply, divide and root units; uses pbfdl_pkg, pbfdl_mul/div/sqrt
module pbfdl_back import pbfdl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        item_valid_i,
  output logic        item_ready_o,
  input  item_t       item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [62:0] density_o,
  output logic [63:0] lambda_o
);

  typedef enum logic [17:0] {
    S_IDLE = 18'h00001,
    S_H2   = 18'h00002,
    S_K1   = 18'h00004,
    S_K2   = 18'h00008,
    S_K3   = 18'h00010,
    S_SQ   = 18'h00020,
    S_SQRT = 18'h00040,
    S_DD   = 18'h00080,
    S_G    = 18'h00100,
    S_DIV  = 18'h00200,
    S_C    = 18'h00400,
    S_CC   = 18'h00800,
    S_FC   = 18'h01000,
    S_FS   = 18'h02000,
    S_FD1  = 18'h04000,
    S_FD2  = 18'h08000,
    S_FQ   = 18'h10000,
    S_OUT  = 18'h20000
  } state_e;

  state_e             state_q;
  item_t              item_q;
  logic [63:0]        h2_q, t_q, tmp_q, r2_q, r_q, g_q, sumc_q, gsq_q, mag_q, lam_q;
  logic [62:0]        dens_q, c_q, dout_q;
  logic [63:0]        gsum_q [3];
  logic [63:0]        lout_q;
  logic [1:0]         axis_q;
  logic               open_q, kw_q, issued_q, neg_q, outv_q;

  logic               mul_start, div_start, sqrt_start;
  logic [63:0]        mul_a, mul_b, div_a, div_d, mul_res, div_res, sqrt_res;
  logic               mul_done, div_done, sqrt_done, unit_done;
  logic [63:0]        hq, rq, dd, r2n, rr, fc_mag;
  logic [62:0]        cc;
  state_e             post_state;

  always_comb begin
    hq         = {33'd0, cfg_i.h} << HqShift;
    rq         = {33'd0, cfg_i.rest} << HqShift;
    dd         = hq - r_q;
    r2n        = add_u64(r2_q, mul_res);
    rr         = (sqrt_res < RMin) ? RMin : sqrt_res;
    cc         = sat63(mul_res);
    fc_mag     = (div_res < OneQ) ? OneQ - div_res : div_res - OneQ;
    post_state = item_q.last ? S_FC : S_IDLE;
    unit_done  = mul_done || div_done || sqrt_done;
  end

  always_comb begin
    mul_start  = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_a      = '0;
    div_d      = '0;
    case (state_q)
      S_H2: begin
        mul_start = !issued_q;
        mul_a     = {17'd0, cfg_i.h, 16'd0};
        mul_b     = {17'd0, cfg_i.h, 16'd0};
      end
      S_K1: begin mul_start = !issued_q; mul_a = t_q; mul_b = t_q; end
      S_K2: begin mul_start = !issued_q; mul_a = tmp_q; mul_b = t_q; end
      S_K3: begin mul_start = !issued_q; mul_a = {1'b0, cfg_i.poly6}; mul_b = tmp_q; end
      S_SQ: begin
        mul_start = !issued_q;
        mul_a     = {16'd0, item_q.mag[axis_q], 16'd0};
        mul_b     = {16'd0, item_q.mag[axis_q], 16'd0};
      end
      S_SQRT: sqrt_start = !issued_q;
      S_DD: begin mul_start = !issued_q; mul_a = dd; mul_b = dd; end
      S_G:  begin mul_start = !issued_q; mul_a = {1'b0, cfg_i.spiky}; mul_b = tmp_q; end
      S_DIV: begin
        div_start = !issued_q;
        div_a     = {32'd0, item_q.mag[axis_q]} << HqShift;
        div_d     = r_q;
      end
      S_C:  begin mul_start = !issued_q; mul_a = g_q; mul_b = tmp_q; end
      S_CC: begin mul_start = !issued_q; mul_a = {1'b0, c_q}; mul_b = {1'b0, c_q}; end
      S_FC: begin div_start = !issued_q; div_a = {1'b0, dens_q}; div_d = rq; end
      S_FS: begin
        mul_start = !issued_q;
        mul_a     = abs64(gsum_q[axis_q]);
        mul_b     = abs64(gsum_q[axis_q]);
      end
      S_FD1: begin div_start = !issued_q; div_a = sumc_q; div_d = rq; end
      S_FD2: begin div_start = !issued_q; div_a = tmp_q; div_d = rq; end
      S_FQ:  begin div_start = !issued_q; div_a = mag_q; div_d = tmp_q; end
      default: ;
    endcase
  end

  assign item_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      open_q   <= 1'b0;
      kw_q     <= 1'b0;
      issued_q <= 1'b0;
      outv_q   <= 1'b0;
      axis_q   <= '0;
    end else begin
      if (mul_start || div_start || sqrt_start) issued_q <= 1'b1;
      if (unit_done) issued_q <= 1'b0;
      if (outv_q && out_ready_i && (state_q != S_OUT)) outv_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (item_valid_i) begin
            axis_q  <= '0;
            state_q <= S_H2;
          end
        end
        S_H2: begin
          if (unit_done) begin
            if (!open_q) begin
              kw_q    <= 1'b1;
              state_q <= S_K1;
            end else if (item_q.present) state_q <= S_SQ;
            else state_q <= post_state;
          end
        end
        S_K1: if (unit_done) state_q <= S_K2;
        S_K2: if (unit_done) state_q <= S_K3;
        S_K3: begin
          if (unit_done) begin
            if (kw_q) begin
              kw_q    <= 1'b0;
              open_q  <= 1'b1;
              state_q <= item_q.present ? S_SQ : post_state;
            end else state_q <= S_SQRT;
          end
        end
        S_SQ: begin
          if (unit_done) begin
            if (axis_q == 2'd2) begin
              axis_q  <= '0;
              state_q <= (r2n <= h2_q) ? S_K1 : S_SQRT;
            end else axis_q <= axis_q + 2'd1;
          end
        end
        S_SQRT: if (unit_done) state_q <= (rr < hq) ? S_DD : post_state;
        S_DD:   if (unit_done) state_q <= S_G;
        S_G: begin
          if (unit_done) begin
            axis_q  <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: if (unit_done) state_q <= S_C;
        S_C:   if (unit_done) state_q <= S_CC;
        S_CC: begin
          if (unit_done) begin
            if (axis_q == 2'd2) begin
              axis_q  <= '0;
              state_q <= post_state;
            end else begin
              axis_q  <= axis_q + 2'd1;
              state_q <= S_DIV;
            end
          end
        end
        S_FC: begin
          if (unit_done) begin
            axis_q  <= '0;
            state_q <= S_FS;
          end
        end
        S_FS: begin
          if (unit_done) begin
            if (axis_q == 2'd2) begin
              axis_q  <= '0;
              state_q <= S_FD1;
            end else axis_q <= axis_q + 2'd1;
          end
        end
        S_FD1: if (unit_done) state_q <= S_FD2;
        S_FD2: if (unit_done) state_q <= S_FQ;
        S_FQ:  if (unit_done) state_q <= S_OUT;
        S_OUT: begin
          if (!outv_q || out_ready_i) begin
            outv_q  <= 1'b1;
            open_q  <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (item_valid_i) item_q <= item_i;
      S_H2: begin
        if (unit_done) begin
          h2_q <= mul_res;
          r2_q <= '0;
          if (!open_q) t_q <= q2f(mul_res);
        end
      end
      S_K1, S_K2: if (unit_done) tmp_q <= mul_res;
      S_K3: begin
        if (unit_done) begin
          if (kw_q) begin
            dens_q    <= sat63(mul_res);
            gsum_q[0] <= '0;
            gsum_q[1] <= '0;
            gsum_q[2] <= '0;
            gsq_q     <= '0;
            r2_q      <= '0;
          end else dens_q <= sat63(add_u64({1'b0, dens_q}, mul_res));
        end
      end
      S_SQ: begin
        if (unit_done) begin
          r2_q <= r2n;
          if (axis_q == 2'd2) t_q <= q2f(h2_q - r2n);
        end
      end
      S_SQRT: if (unit_done) r_q <= rr;
      S_DD:   if (unit_done) tmp_q <= mul_res;
      S_G:    if (unit_done) g_q <= mul_res;
      S_DIV:  if (unit_done) tmp_q <= div_res;
      S_C: begin
        if (unit_done) begin
          c_q <= cc;
          gsum_q[axis_q] <= add_s64(gsum_q[axis_q],
                                    item_q.neg[axis_q] ? 64'd0 - {1'b0, cc} : {1'b0, cc});
        end
      end
      S_CC: if (unit_done) gsq_q <= add_u64(gsq_q, mul_res);
      S_FC: begin
        if (unit_done) begin
          neg_q  <= (div_res < OneQ);
          mag_q  <= {1'b0, sat63(fc_mag)};
          sumc_q <= gsq_q;
        end
      end
      S_FS:  if (unit_done) sumc_q <= add_u64(sumc_q, mul_res);
      S_FD1: if (unit_done) tmp_q <= div_res;
      S_FD2: if (unit_done) tmp_q <= add_u64(div_res, OneQ);
      S_FQ: begin
        if (unit_done) begin
          lam_q <= neg_q ? {1'b0, sat63(div_res)} : 64'd0 - {1'b0, sat63(div_res)};
        end
      end
      S_OUT: begin
        if (!outv_q || out_ready_i) begin
          dout_q <= dens_q;
          lout_q <= lam_q;
        end
      end
      default: ;
    endcase
  end

  pbfdl_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  pbfdl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (div_a),
    .d_i     (div_d),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  pbfdl_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .v_i     (r2_q),
    .done_o  (sqrt_done),
    .res_o   (sqrt_res)
  );

  assign out_valid_o = outv_q;
  assign density_o   = dout_q;
  assign lambda_o    = lout_q;

endmodule

// File: hdl/pbf_density_lambda_unit.sv
`timescale 1ns / 1ps
// pbf_density_lambda_unit: top level, config registers, front queue and
// back sequencer; uses pbfdl_pkg, pbfdl_front, pbfdl_back
//
//  channel | signals                                   | direction
//  in      | in_valid_i/in_ready_o, center_*, neighbor_* | pair beat in
//  out     | out_valid_o/out_ready_i, density, lambda    | result beat out
//  cfg     | psel/penable/pwrite/paddr/pwdata/prdata     | register access
//
// a beat takes longer when the neighbor lies within h than beyond it, set by
// the 64-step divider and root units; a beat that opens a group adds the
// self kernel term, a last beat adds the lambda computation
// reset clears the queue, the sequencer and the registers to defaults
// the front queue takes two beats while the back works or the output waits
module pbf_density_lambda_unit import pbfdl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] center_z_i,
  input  logic signed [31:0] neighbor_x_i,
  input  logic signed [31:0] neighbor_y_i,
  input  logic signed [31:0] neighbor_z_i,
  input  logic               neighbor_present_i,
  input  logic               last_neighbor_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [62:0]        density_out_o,
  output logic [63:0]        lambda_out_o
);

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     wr_en;
  logic     item_valid, item_ready;
  item_t    item;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[4:3]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.h     <= HReset;
      cfg_q.poly6 <= Poly6Reset;
      cfg_q.spiky <= SpikyReset;
      cfg_q.rest  <= RestReset;
    end else if (wr_en) begin
      case (reg_idx)
        REG_H:     cfg_q.h     <= pwdata[30:0];
        REG_POLY6: cfg_q.poly6 <= pwdata[62:0];
        REG_SPIKY: cfg_q.spiky <= pwdata[62:0];
        REG_REST:  cfg_q.rest  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_H:     prdata = {33'd0, cfg_q.h};
      REG_POLY6: prdata = {1'b0, cfg_q.poly6};
      REG_SPIKY: prdata = {1'b0, cfg_q.spiky};
      REG_REST:  prdata = {33'd0, cfg_q.rest};
      default:   prdata = '0;
    endcase
  end

  pbfdl_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .center_x_i         (center_x_i),
    .center_y_i         (center_y_i),
    .center_z_i         (center_z_i),
    .neighbor_x_i       (neighbor_x_i),
    .neighbor_y_i       (neighbor_y_i),
    .neighbor_z_i       (neighbor_z_i),
    .neighbor_present_i (neighbor_present_i),
    .last_neighbor_i    (last_neighbor_i),
    .item_valid_o       (item_valid),
    .item_ready_i       (item_ready),
    .item_o             (item)
  );

  pbfdl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .density_o    (density_out_o),
    .lambda_o     (lambda_out_o)
  );

endmodule
